/* design/a4sd_pkg.sv */
`default_nettype none

package a4sd_pkg;

  // History fixed point and filter gain scaling.
  localparam int HIST_FRAC_BITS_DEF = 6;
  localparam int HIST_W             = 32;
  localparam int GAIN_FRAC_BITS     = 6;
  localparam int GAIN_W             = 8;
  localparam int PCM_W              = 16;

  // Block layout: header byte, flag byte, then data bytes.
  localparam int                 POS_W     = 4;
  localparam logic [POS_W-1:0]   POS_HDR   = 4'd0;
  localparam logic [POS_W-1:0]   POS_FLAG  = 4'd1;
  localparam logic [POS_W-1:0]   POS_LAST  = 4'd15;

  // Predictor indices; all but FILT_NONE have a nonzero gain.
  localparam logic [3:0] FILT_NONE = 4'd0;
  localparam logic [3:0] FILT_ONE  = 4'd1;
  localparam logic [3:0] FILT_TWO  = 4'd2;
  localparam logic [3:0] FILT_THREE = 4'd3;
  localparam logic [3:0] FILT_FOUR = 4'd4;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Output saturation limits.
  localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sh7FFF;
  localparam logic signed [PCM_W-1:0] PCM_MIN = -16'sh8000;
  localparam logic signed [HIST_W-1:0] HIST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [HIST_W-1:0] HIST_MIN = -32'sh8000_0000;

  // One data byte with the header fields in force when it arrived.
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] shift;
    logic [3:0] filt;
  } q_entry_t;

  // Write side of the queue.
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  // Read side of the queue.
  typedef struct packed {
    logic     empty;
    q_entry_t head;
  } q_status_t;

  // Gain on the newer history sample, in sixty-fourths.
  function automatic logic signed [GAIN_W-1:0] gain_newer(input logic [3:0] filt);
    logic signed [GAIN_W-1:0] g;
    case (filt)
      FILT_NONE:  g = 8'sd0;
      FILT_ONE:   g = 8'sd60;
      FILT_TWO:   g = 8'sd115;
      FILT_THREE: g = 8'sd98;
      FILT_FOUR:  g = 8'sd122;
      default:    g = 8'sd0;
    endcase
    return g;
  endfunction

  // Gain on the older history sample, in sixty-fourths.
  function automatic logic signed [GAIN_W-1:0] gain_older(input logic [3:0] filt);
    logic signed [GAIN_W-1:0] g;
    case (filt)
      FILT_NONE:  g = 8'sd0;
      FILT_ONE:   g = 8'sd0;
      FILT_TWO:   g = -8'sd52;
      FILT_THREE: g = -8'sd55;
      FILT_FOUR:  g = -8'sd60;
      default:    g = 8'sd0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

/* design/a4sd_if.sv */
`default_nettype none

// Compressed byte channel.
interface a4sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

// Decoded sample channel.
interface a4sd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic               last_of_pair;

  modport source (output valid, output pcm_sample, output last_of_pair, input ready);
  modport sink (input valid, input pcm_sample, input last_of_pair, output ready);
endinterface

`default_nettype wire

/* design/adpcm_4bit_sample_decoder_unit.sv */
`default_nettype none

// Channel   Direction  Payload                          Transfer
// in_ch     sink       stream_byte[7:0]                 valid && ready
// out_ch    source     pcm_sample[15:0], last_of_pair   valid && ready
//
// A data byte yields two samples, low nibble first; header and flag bytes
// produce nothing. The throughput is set by the history recurrence, one
// sample per cycle while a byte is queued and the output register is free.
// A data byte reaches out_ch through the byte queue and the output register.
// Reset is synchronous, active low, and clears position, header and history.
// A two-entry byte queue and the output register let either side stall alone.
module adpcm_4bit_sample_decoder_unit
  import a4sd_pkg::*;
#(
  parameter int HISTORY_FRAC_BITS = HIST_FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  a4sd_in_if.sink     in_ch,
  a4sd_out_if.source  out_ch
);

  q_push_t   q_wr;
  q_status_t q_rd;
  logic      q_full;
  logic      q_pop;

  // Byte classification and header capture.
  a4sd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  // Data byte queue.
  a4sd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .q_rd  (q_rd)
  );

  // Sample reconstruction and output register.
  a4sd_back #(
    .HISTORY_FRAC_BITS (HISTORY_FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

/* design/a4sd_front.sv */
`default_nettype none

module a4sd_front
  import a4sd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  a4sd_in_if.sink     in_ch,
  input  wire logic   q_full,
  output q_push_t     q_wr
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       shift_r, shift_nxt;
  logic [3:0]       filt_r, filt_nxt;
  logic             is_data;
  logic             xfer;

  // Header and flag bytes never need queue space.
  assign is_data     = (pos_r != POS_HDR) && (pos_r != POS_FLAG);
  assign in_ch.ready = !is_data || !q_full;
  assign xfer        = in_ch.valid && in_ch.ready;

  // Data bytes go to the queue tagged with the current header fields.
  assign q_wr.push        = xfer && is_data;
  assign q_wr.entry.data  = in_ch.stream_byte;
  assign q_wr.entry.shift = shift_r;
  assign q_wr.entry.filt  = filt_r;

  // Byte position and header capture.
  always_comb begin
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    filt_nxt  = filt_r;
    if (xfer) begin
      pos_nxt = pos_r + 1'b1;
      if (pos_r == POS_HDR) begin
        filt_nxt  = in_ch.stream_byte[7:4];
        shift_nxt = in_ch.stream_byte[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      shift_r <= '0;
      filt_r  <= '0;
    end else begin
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      filt_r  <= filt_nxt;
    end
  end

  // The position wraps from the last byte back to the header.
  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && pos_r == POS_LAST) |=> (pos_r == POS_HDR))
    else $error("byte position did not wrap at end of block");

endmodule

`default_nettype wire

/* design/a4sd_queue.sv */
`default_nettype none

module a4sd_queue
  import a4sd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_push_t q_wr,
  input  wire logic    pop,
  output logic         full,
  output q_status_t    q_rd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_rd.empty = (count_r == '0);
  assign q_rd.head  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_wr.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_wr.push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !q_wr.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_rd.empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

/* design/a4sd_back.sv */
`default_nettype none

module a4sd_back
  import a4sd_pkg::*;
#(
  parameter int HISTORY_FRAC_BITS = HIST_FRAC_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_status_t q_rd,
  output logic           pop,
  a4sd_out_if.source     out_ch
);

  // Widths of the prediction sum and the rounding path.
  localparam int PROD_W = HIST_W + GAIN_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = HIST_W + 1;
  localparam logic signed [RND_W-1:0] HALF    = RND_W'(1) <<< (HISTORY_FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] ONE_M1  = (RND_W'(1) <<< HISTORY_FRAC_BITS) - RND_W'(1);

  logic signed [HIST_W-1:0] hist_newer_r, hist_newer_nxt;
  logic signed [HIST_W-1:0] hist_older_r, hist_older_nxt;
  logic                     phase_r, phase_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [PCM_W-1:0]  out_sample_r, out_sample_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     load;
  logic [3:0]               nib;
  logic signed [PCM_W-1:0]  base16;
  logic signed [GAIN_W-1:0] gp, gn;
  logic signed [PROD_W-1:0] prod_n, prod_o;
  logic signed [SUM_W-1:0]  sum;
  logic signed [HIST_W-1:0] hist_new;
  logic signed [RND_W-1:0]  rnd;
  logic signed [RND_W-1:0]  quot;
  logic signed [PCM_W-1:0]  pcm;

  // A sample is produced whenever a byte waits and the output register is free.
  assign load = !q_rd.empty && (!out_valid_r || out_ch.ready);
  assign pop  = load && phase_r;

  // Scaled nibble plus the two-tap prediction, saturated to history width.
  always_comb begin
    nib    = phase_r ? q_rd.head.data[7:4] : q_rd.head.data[3:0];
    base16 = $signed({nib, 12'b0}) >>> q_rd.head.shift;
    gp     = gain_newer(q_rd.head.filt);
    gn     = gain_older(q_rd.head.filt);
    prod_n = PROD_W'(hist_newer_r) * PROD_W'(gp);
    prod_o = PROD_W'(hist_older_r) * PROD_W'(gn);
    sum    = (SUM_W'(base16) <<< HISTORY_FRAC_BITS)
           + SUM_W'(prod_n >>> GAIN_FRAC_BITS)
           + SUM_W'(prod_o >>> GAIN_FRAC_BITS);
    if (sum > SUM_W'(HIST_MAX)) begin
      hist_new = HIST_MAX;
    end else if (sum < SUM_W'(HIST_MIN)) begin
      hist_new = HIST_MIN;
    end else begin
      hist_new = HIST_W'(sum);
    end
  end

  // Add one half, truncate toward zero, saturate to the sample width.
  always_comb begin
    rnd = RND_W'(hist_new) + HALF;
    if (rnd < 0) begin
      quot = (rnd + ONE_M1) >>> HISTORY_FRAC_BITS;
    end else begin
      quot = rnd >>> HISTORY_FRAC_BITS;
    end
    if (quot > RND_W'(PCM_MAX)) begin
      pcm = PCM_MAX;
    end else if (quot < RND_W'(PCM_MIN)) begin
      pcm = PCM_MIN;
    end else begin
      pcm = PCM_W'(quot);
    end
  end

  // History, nibble phase and output register.
  always_comb begin
    hist_newer_nxt = hist_newer_r;
    hist_older_nxt = hist_older_r;
    phase_nxt      = phase_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      hist_newer_nxt = hist_new;
      hist_older_nxt = hist_newer_r;
      phase_nxt      = !phase_r;
      out_valid_nxt  = 1'b1;
      out_sample_nxt = pcm;
      out_last_nxt   = phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_newer_r <= '0;
      hist_older_r <= '0;
      phase_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hist_newer_r <= hist_newer_nxt;
      hist_older_r <= hist_older_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pcm_sample   = out_sample_r;
  assign out_ch.last_of_pair = out_last_r;

  // A low-nibble sample is always followed by the high nibble of the same byte.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !phase_r) |=> (phase_r && !q_rd.empty))
    else $error("high nibble missing after low nibble");

  // The history shifts by exactly one sample on every produced sample.
  a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (hist_older_r == $past(hist_newer_r)))
    else $error("history did not shift with a new sample");

endmodule

`default_nettype wire
